FILE: design/pie_pkg.sv
// Shared types, codes and a helper function for the prefix instruction encoder.
`default_nettype none
package pie_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned NIBBLE_W = 4;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 3;

   localparam logic [1:0] OP_DIRECT  = 2'd0;
   localparam logic [1:0] OP_OPERATE = 2'd1;
   localparam logic [1:0] OP_LDC_OPR = 2'd2;
   localparam logic [1:0] OP_DATA    = 2'd3;

   localparam logic [NIBBLE_W-1:0] FN_PFIX = 4'h2;
   localparam logic [NIBBLE_W-1:0] FN_LDC  = 4'h4;
   localparam logic [NIBBLE_W-1:0] FN_NFIX = 4'h6;
   localparam logic [NIBBLE_W-1:0] FN_OPR  = 4'hf;

   localparam logic [COUNT_W-1:0] DATA_LAST_COUNT = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SECOND,
      ST_DATA
   } pie_state_type;

   typedef struct packed {
      logic              load_prefix;
      logic              load_data;
      logic              shift_nibble;
      logic              shift_byte;
      logic [WORD_W-1:0] value;
   } pie_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic                neg;
      logic [NIBBLE_W-1:0] nibble;
      logic [BYTE_W-1:0]   low_byte;
   } pie_status_type;

   // Index of the most significant nonzero nibble, zero when the word is zero.
   function automatic logic [COUNT_W-1:0] top_nibble(input logic [WORD_W-1:0] v);
      logic [COUNT_W-1:0] h;
      h = '0;
      for (int i = 0; i < WORD_W / NIBBLE_W; i++) begin
         if (|v[i*NIBBLE_W +: NIBBLE_W]) begin
            h = COUNT_W'(i);
         end
      end
      return h;
   endfunction

endpackage
`default_nettype wire

FILE: design/pie_digit_shift.sv
// Operand shift register that presents one prefix nibble or one data byte per step.
`default_nettype none
module pie_digit_shift (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pie_pkg::pie_cmd_type    cmd,
   output      pie_pkg::pie_status_type status
);

   logic [pie_pkg::WORD_W-1:0]  shreg_ff, shreg_in;
   logic [pie_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        neg_ff, neg_in;

   logic                        neg;
   logic [pie_pkg::WORD_W-1:0]  mag;
   logic [pie_pkg::COUNT_W-1:0] high;
   logic [pie_pkg::COUNT_W-1:0] levels;
   logic [pie_pkg::WORD_W-1:0]  base;

   always_comb begin
      neg    = cmd.value[pie_pkg::WORD_W-1];
      mag    = neg ? ~cmd.value : cmd.value;
      high   = pie_pkg::top_nibble(mag);
      levels = (neg && (high == '0)) ? pie_pkg::COUNT_W'(1) : high;
      base   = {mag[pie_pkg::WORD_W-1:pie_pkg::NIBBLE_W],
                cmd.value[pie_pkg::NIBBLE_W-1:0]};

      shreg_in = shreg_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      if (cmd.load_prefix) begin
         shreg_in = base << {~levels, 2'b00};
         count_in = levels;
         neg_in   = neg;
      end else if (cmd.load_data) begin
         shreg_in = cmd.value;
         count_in = pie_pkg::DATA_LAST_COUNT;
         neg_in   = 1'b0;
      end else if (cmd.shift_nibble) begin
         shreg_in = shreg_ff << pie_pkg::NIBBLE_W;
         count_in = count_ff - pie_pkg::COUNT_W'(1);
      end else if (cmd.shift_byte) begin
         shreg_in = shreg_ff >> pie_pkg::BYTE_W;
         count_in = count_ff - pie_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         neg_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         neg_ff   <= neg_in;
      end
      shreg_ff <= shreg_in;
   end

   assign status = '{count:    count_ff,
                     neg:      neg_ff,
                     nibble:   shreg_ff[pie_pkg::WORD_W-1 -: pie_pkg::NIBBLE_W],
                     low_byte: shreg_ff[pie_pkg::BYTE_W-1:0]};

endmodule
`default_nettype wire

FILE: design/pie_ctrl.sv
// Sequencer that picks the function nibble of each byte and steps the shift register.
`default_nettype none
module pie_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [1:0]                  req_operation,
   input  wire logic [3:0]                  req_function_code,
   input  wire logic [31:0]                 req_operand,
   input  wire logic [7:0]                  req_second_code,
   input  wire logic                        out_free,
   input  wire pie_pkg::pie_status_type     status,
   output      pie_pkg::pie_cmd_type        cmd,
   output      logic                        emit,
   output      logic [pie_pkg::BYTE_W-1:0]  emit_byte,
   output      logic                        emit_last
);

   pie_pkg::pie_state_type state_ff, state_in;
   logic [1:0]                   op_ff, op_in;
   logic [pie_pkg::NIBBLE_W-1:0] func_ff, func_in;
   logic [pie_pkg::BYTE_W-1:0]   second_ff, second_in;

   logic [pie_pkg::NIBBLE_W-1:0] base_fn;
   logic [pie_pkg::NIBBLE_W-1:0] byte_fn;

   always_comb begin
      case (op_ff)
         pie_pkg::OP_DIRECT:  base_fn = func_ff;
         pie_pkg::OP_LDC_OPR: base_fn = pie_pkg::FN_LDC;
         default:             base_fn = pie_pkg::FN_OPR;
      endcase
      if (state_ff == pie_pkg::ST_SECOND) begin
         base_fn = pie_pkg::FN_OPR;
      end
      if (status.count == '0) begin
         byte_fn = base_fn;
      end else if ((status.count == pie_pkg::COUNT_W'(1)) && status.neg) begin
         byte_fn = pie_pkg::FN_NFIX;
      end else begin
         byte_fn = pie_pkg::FN_PFIX;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      func_in   = func_ff;
      second_in = second_ff;
      req_ready = 1'b0;
      emit      = 1'b0;
      emit_byte = {byte_fn, status.nibble};
      emit_last = 1'b0;
      cmd       = '0;
      cmd.value = req_operand;

      case (state_ff)
         pie_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_operation;
               func_in   = req_function_code;
               second_in = req_second_code;
               if (req_operation == pie_pkg::OP_DATA) begin
                  cmd.load_data = 1'b1;
                  state_in      = pie_pkg::ST_DATA;
               end else begin
                  cmd.load_prefix = 1'b1;
                  state_in        = pie_pkg::ST_FIRST;
               end
            end
         end
         pie_pkg::ST_FIRST: begin
            if (out_free) begin
               emit = 1'b1;
               if (status.count == '0) begin
                  if (op_ff == pie_pkg::OP_LDC_OPR) begin
                     cmd.load_prefix = 1'b1;
                     cmd.value       = {{(pie_pkg::WORD_W-pie_pkg::BYTE_W){1'b0}}, second_ff};
                     state_in        = pie_pkg::ST_SECOND;
                  end else begin
                     emit_last = 1'b1;
                     state_in  = pie_pkg::ST_IDLE;
                  end
               end else begin
                  cmd.shift_nibble = 1'b1;
               end
            end
         end
         pie_pkg::ST_SECOND: begin
            if (out_free) begin
               emit = 1'b1;
               if (status.count == '0) begin
                  emit_last = 1'b1;
                  state_in  = pie_pkg::ST_IDLE;
               end else begin
                  cmd.shift_nibble = 1'b1;
               end
            end
         end
         pie_pkg::ST_DATA: begin
            emit_byte = status.low_byte;
            if (out_free) begin
               emit = 1'b1;
               if (status.count == '0) begin
                  emit_last = 1'b1;
                  state_in  = pie_pkg::ST_IDLE;
               end else begin
                  cmd.shift_byte = 1'b1;
               end
            end
         end
         default: begin
            state_in = pie_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pie_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff     <= op_in;
      func_ff   <= func_in;
      second_ff <= second_in;
   end

endmodule
`default_nettype wire

FILE: design/prefix_instruction_encoder_top.sv
// Top level of the prefix instruction encoder with its result register.
// The operand is loaded into the shift register on acceptance; the first byte then goes into the result register.
// Throughput: one byte per cycle while the result register is free, from the single shift register
// that emits one prefix-coded byte or one data byte a step.
// A new request is taken only once the last byte of the previous one is in the result register.
// Reset is synchronous and clears the sequencer state and the result valid flag.
`default_nettype none
module prefix_instruction_encoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [3:0]  req_function_code,
   input  wire logic signed [31:0] req_operand,
   input  wire logic [7:0]  req_second_code,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_code_byte,
   output      logic        rsp_last
);

   pie_pkg::pie_cmd_type    cmd;
   pie_pkg::pie_status_type status;

   logic                       out_free;
   logic                       emit;
   logic [pie_pkg::BYTE_W-1:0] emit_byte;
   logic                       emit_last;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [pie_pkg::BYTE_W-1:0] rsp_code_byte_ff, rsp_code_byte_in;
   logic                       rsp_last_ff, rsp_last_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   pie_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_function_code (req_function_code),
      .req_operand       ($unsigned(req_operand)),
      .req_second_code   (req_second_code),
      .out_free          (out_free),
      .status            (status),
      .cmd               (cmd),
      .emit              (emit),
      .emit_byte         (emit_byte),
      .emit_last         (emit_last)
   );

   pie_digit_shift u_shift (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_code_byte_in = rsp_code_byte_ff;
      rsp_last_in      = rsp_last_ff;
      if (emit) begin
         rsp_valid_in     = 1'b1;
         rsp_code_byte_in = emit_byte;
         rsp_last_in      = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_code_byte_ff <= rsp_code_byte_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_byte = rsp_code_byte_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
`default_nettype wire

FILE: tb/sv/prefix_instruction_encoder_top_test.sv
// Self-checking testbench for the prefix instruction encoder, with a built-in byte predictor.
module prefix_instruction_encoder_top_test;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last;
   } code_byte_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_operation = pie_pkg::OP_DIRECT;
   logic [3:0]        req_function_code = '0;
   logic signed [31:0] req_operand = '0;
   logic [7:0]        req_second_code = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_code_byte;
   logic              rsp_last;

   code_byte_entry_type expected_code_bytes[$];
   logic [7:0]        run_bytes[$];
   int                error_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_idle_pct = 0;
   int                hold_cycles = 0;

   prefix_instruction_encoder_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_function_code (req_function_code),
      .req_operand       (req_operand),
      .req_second_code   (req_second_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_byte     (rsp_code_byte),
      .rsp_last          (rsp_last)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      code_byte_entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_code_bytes.size() == 0) begin
            $error("unexpected result: code_byte %h last %b", rsp_code_byte, rsp_last);
            error_count++;
         end else begin
            want = expected_code_bytes.pop_front();
            if (rsp_code_byte !== want.code_byte) begin
               $error("code_byte mismatch: expected %h, actual %h",
                      want.code_byte, rsp_code_byte);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch: expected %b, actual %b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Prefix bytes are found from the low nibble upward, so each one goes in front.
   function automatic void add_prefixed_run(input logic [3:0] fn, input longint value);
      longint     e;
      logic [3:0] f;
      logic [7:0] run[$];
      f = fn;
      e = value;
      run.push_front({f, e[3:0]});
      while (e >= 16 || e < 0) begin
         if (e >= 16) begin
            f = pie_pkg::FN_PFIX;
            e = e >>> 4;
         end else begin
            f = pie_pkg::FN_NFIX;
            e = (~e) >>> 4;
         end
         run.push_front({f, e[3:0]});
      end
      foreach (run[i]) begin
         run_bytes.push_back(run[i]);
      end
   endfunction

   function automatic void encode_request(input logic [1:0] op, input logic [3:0] fn,
                                          input logic signed [31:0] operand,
                                          input logic [7:0] second_code);
      longint value;
      value = operand;
      run_bytes.delete();
      case (op)
         pie_pkg::OP_DIRECT:  add_prefixed_run(fn, value);
         pie_pkg::OP_OPERATE: add_prefixed_run(pie_pkg::FN_OPR, value);
         pie_pkg::OP_LDC_OPR: begin
            add_prefixed_run(pie_pkg::FN_LDC, value);
            add_prefixed_run(pie_pkg::FN_OPR, longint'(second_code));
         end
         default: begin
            for (int i = 0; i < 4; i++) begin
               run_bytes.push_back(operand[8*i +: 8]);
            end
         end
      endcase
      foreach (run_bytes[i]) begin
         expected_code_bytes.push_back('{code_byte: run_bytes[i],
                                        last: (i == run_bytes.size() - 1)});
      end
   endfunction

   function automatic logic [31:0] random_operand();
      int unsigned k;
      k = $urandom_range(31);
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'($urandom_range(63)) - 32'd32;
         2: return 32'd1 << k;
         3: return (32'd1 << k) - 32'd1;
         default: return -(32'd1 << k);
      endcase
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [3:0] fn,
                               input logic [31:0] operand, input logic [7:0] second_code);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_function_code <= fn;
      req_operand <= operand;
      req_second_code <= second_code;
      do @(posedge clock); while (!req_ready);
      encode_request(op, fn, operand, second_code);
      @(negedge clock);
   endtask

   task automatic send_random_request();
      send_request(2'($urandom_range(3)), 4'($urandom_range(15)), random_operand(),
                   8'($urandom_range(255)));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_code_bytes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic test_directed();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      send_request(pie_pkg::OP_DIRECT, 4'd0, 32'd0, 8'd0);
      send_request(pie_pkg::OP_DIRECT, 4'd1, 32'd15, 8'hff);
      send_request(pie_pkg::OP_DIRECT, 4'd2, 32'd16, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd3, -32'sd1, 8'h5a);
      send_request(pie_pkg::OP_DIRECT, 4'd4, -32'sd16, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd5, -32'sd17, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd6, 32'h7fff_ffff, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd7, 32'h8000_0000, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd8, 32'd256, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd9, -32'sd256, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd10, 32'h1234_5678, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd11, -32'sh1234_5678, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd12, 32'd1, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd13, 32'd255, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd14, -32'sd2, 8'h00);
      send_request(pie_pkg::OP_DIRECT, 4'd15, 32'h10, 8'h00);
      send_request(pie_pkg::OP_OPERATE, 4'd9, 32'h7fff_ffff, 8'h33);
      send_request(pie_pkg::OP_OPERATE, 4'd15, -32'sd1, 8'h00);
      send_request(pie_pkg::OP_OPERATE, 4'd0, 32'h8000_0000, 8'hff);
      send_request(pie_pkg::OP_LDC_OPR, 4'd15, 32'h8000_0000, 8'hff);
      send_request(pie_pkg::OP_LDC_OPR, 4'd0, 32'd0, 8'h00);
      send_request(pie_pkg::OP_LDC_OPR, 4'd7, -32'sd1, 8'h10);
      send_request(pie_pkg::OP_DATA, 4'd15, 32'hffff_ffff, 8'hff);
      send_request(pie_pkg::OP_DATA, 4'd0, 32'h0000_0000, 8'h00);
      send_request(pie_pkg::OP_DATA, 4'd3, 32'h8000_0001, 8'h81);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (count) send_random_request();
      wait_for_results();
   endtask

   // The receiver stops for a long stretch so that the encoder fills up and stalls requests.
   task automatic test_input_stall();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      @(posedge clock);
      hold_cycles = 150;
      @(negedge clock);
      repeat (25) send_random_request();
      wait_for_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_traffic(140, 33, 65);
      test_random_traffic(140, 65, 33);
      test_random_traffic(140, 0, 0);
      test_input_stall();
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
